/* hw/rtl/rmc_pkg.sv */
package rmc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 128;

    localparam int VERT_W  = $clog2(MAX_VERTICES);       // vertex id
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);   // vertex count
    localparam int EADDR_W = $clog2(MAX_EDGES);          // edge store address
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);      // edge count
    localparam int TRIAL_W = 16;
    localparam int LFSR_W  = 32;
    localparam int CUT_W   = 7;
    localparam int DCNT_W  = $clog2(LFSR_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 2'd2;

    localparam logic [VCNT_W-1:0]  VCOUNT_RESET = VCNT_W'(4);
    localparam logic [TRIAL_W-1:0] TRIALS_RESET = TRIAL_W'(1600);
    localparam logic [LFSR_W-1:0]  LFSR_TAPS    = 32'hD000_0001;
    localparam logic [CUT_W-1:0]   CUT_CEILING  = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_CHECK,
        ST_DIV,
        ST_FETCH,
        ST_EDGE,
        ST_FIND_A,
        ST_FIND_B,
        ST_EVAL,
        ST_TRIAL_END,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_CONN,
        PH_RAND,
        PH_COUNT
    } phase_t;

    typedef struct packed {
        logic in_ready;
        logic load_row;
        logic scan_step;
        logic clear_start;
        logic clear_step;
        logic e_clear;
        logic e_next;
        logic div_start;
        logic div_step;
        logic edge_rd;
        logic find_a_start;
        logic walk;
        logic find_b_start;
        logic join_roots;
        logic count_clear;
        logic count;
        logic set_flag;
        logic trial_init;
        logic trial_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic scan_done;
        logic last_row;
        logic clear_last;
        logic total_zero;
        logic comps_one;
        logic comps_gt2;
        logic div_last;
        logic root_hit;
        logic roots_differ;
        logic e_last;
        logic trials_last;
        logic out_free;
    } stat_t;

endpackage

/* hw/rtl/rmc_if.sv */
interface rmc_row_if;
    import rmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [VERT_W-1:0] row_index;
    logic [15:0]       row_bits;
    logic              last_row;

    modport source (output valid, row_index, row_bits, last_row, input ready);
    modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface rmc_res_if;
    import rmc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CUT_W-1:0] min_cut;
    logic             disconnected;

    modport source (output valid, min_cut, disconnected, input ready);
    modport sink   (input valid, min_cut, disconnected, output ready);
endinterface

/* hw/rtl/rmc_ram.sv */
module rmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/rmc_ctrl.sv */
module rmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  rmc_pkg::stat_t st,
    output rmc_pkg::cmd_t  cmd
);
    import rmc_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CONN;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    if (st.last_row)
                    begin
                        state_next = ST_CLEAR;
                        phase_next = PH_CONN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    if (phase_reg == PH_CONN)
                    begin
                        state_next = st.total_zero ? ST_EVAL : ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (st.comps_gt2)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FETCH;
                    phase_next = PH_COUNT;
                end
            end
            ST_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                state_next = ST_FIND_A;
            end
            ST_FIND_A:
            begin
                if (st.root_hit)
                begin
                    state_next = ST_FIND_B;
                end
            end
            ST_FIND_B:
            begin
                if (st.root_hit)
                begin
                    unique case (phase_reg)
                        PH_CONN:  state_next = st.e_last ? ST_EVAL : ST_FETCH;
                        PH_RAND:  state_next = ST_CHECK;
                        PH_COUNT: state_next = st.e_last ? ST_TRIAL_END : ST_FETCH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (st.total_zero || !st.comps_one)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CLEAR;
                    phase_next = PH_RAND;
                end
            end
            ST_TRIAL_END:
            begin
                if (st.trials_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CLEAR;
                    phase_next = PH_RAND;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load_row = st.in_valid;
            end
            ST_SCAN:
            begin
                if (!st.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (st.last_row)
                begin
                    cmd.clear_start = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last && phase_reg == PH_CONN && !st.total_zero)
                begin
                    cmd.e_clear = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (st.comps_gt2)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.e_clear     = 1'b1;
                    cmd.count_clear = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.edge_rd = 1'b1;
            end
            ST_EDGE:
            begin
                cmd.find_a_start = 1'b1;
            end
            ST_FIND_A:
            begin
                cmd.walk         = 1'b1;
                cmd.find_b_start = st.root_hit;
            end
            ST_FIND_B:
            begin
                cmd.walk = 1'b1;
                if (st.root_hit)
                begin
                    if (phase_reg == PH_COUNT)
                    begin
                        cmd.count = 1'b1;
                    end
                    else
                    begin
                        cmd.join_roots = st.roots_differ;
                    end
                    if (phase_reg != PH_RAND && !st.e_last)
                    begin
                        cmd.e_next = 1'b1;
                    end
                end
            end
            ST_EVAL:
            begin
                if (st.total_zero || !st.comps_one)
                begin
                    cmd.set_flag = 1'b1;
                end
                else
                begin
                    cmd.trial_init  = 1'b1;
                    cmd.clear_start = 1'b1;
                end
            end
            ST_TRIAL_END:
            begin
                cmd.trial_end   = 1'b1;
                cmd.clear_start = !st.trials_last;
            end
            ST_DONE:
            begin
                cmd.out_load = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

/* hw/rtl/rmc_dp.sv */
module rmc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    rmc_row_if.sink                          rows,
    rmc_res_if.source                        cuts,
    input  rmc_pkg::cmd_t                    cmd,
    output rmc_pkg::stat_t                   st
);
    import rmc_pkg::*;

    logic [VCNT_W-1:0]  vcount_reg;
    logic [TRIAL_W-1:0] tcount_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [VCNT_W-1:0]  n;

    logic [VERT_W-1:0]  row_reg;
    logic [15:0]        bits_reg;
    logic               last_reg;
    logic [VCNT_W-1:0]  j_reg;
    logic [ECNT_W-1:0]  total_reg;
    logic [ECNT_W-1:0]  e_reg;
    logic [VERT_W-1:0]  k_reg;
    logic [VCNT_W-1:0]  comps_reg;
    logic [VERT_W-1:0]  cur_reg;
    logic [VERT_W-1:0]  root_a_reg;
    logic [VERT_W-1:0]  eb_reg;
    logic [EADDR_W-1:0] rem_reg;
    logic [LFSR_W-1:0]  dvd_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [CUT_W-1:0]   cut_reg;
    logic [CUT_W-1:0]   best_reg;
    logic [TRIAL_W-1:0] trials_reg;
    logic               flag_reg;
    logic               out_valid_reg;
    logic [CUT_W-1:0]   out_cut_reg;
    logic               out_flag_reg;

    logic [LFSR_W-1:0]      lfsr_next;
    logic [EADDR_W:0]       rem_shift;
    logic [EADDR_W:0]       rem_next;
    logic                   edge_we;
    logic [2*VERT_W-1:0]    edge_rdata;
    logic                   par_we;
    logic [VERT_W-1:0]      par_waddr;
    logic [VERT_W-1:0]      par_wdata;
    logic                   par_re;
    logic [VERT_W-1:0]      par_raddr;
    logic [VERT_W-1:0]      pdata;
    logic [LFSR_W-1:0]      seed_load;

    always_comb
    begin
        if (vcount_reg < VCNT_W'(2))
        begin
            n = VCNT_W'(2);
        end
        else if (vcount_reg > VCNT_W'(MAX_VERTICES))
        begin
            n = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            n = vcount_reg;
        end
    end

    assign lfsr_next = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign seed_load = (cfg_data[LFSR_W-1:0] == '0) ? LFSR_W'(1) : cfg_data[LFSR_W-1:0];

    // one remainder bit per cycle, lfsr mod edge count
    assign rem_shift = {rem_reg, dvd_reg[LFSR_W-1]};
    assign rem_next  = (rem_shift >= total_reg) ? rem_shift - total_reg : rem_shift;

    assign edge_we = cmd.scan_step && bits_reg[j_reg[VERT_W-1:0]]
                     && !total_reg[ECNT_W-1];

    rmc_ram #(.WIDTH(2*VERT_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk   (clk),
        .we    (edge_we),
        .waddr (total_reg[EADDR_W-1:0]),
        .wdata ({row_reg, j_reg[VERT_W-1:0]}),
        .re    (cmd.edge_rd),
        .raddr (e_reg[EADDR_W-1:0]),
        .rdata (edge_rdata)
    );

    assign par_we    = cmd.clear_step || cmd.join_roots;
    assign par_waddr = cmd.clear_step ? k_reg : root_a_reg;
    assign par_wdata = cmd.clear_step ? k_reg : cur_reg;
    assign par_re    = cmd.find_a_start || cmd.walk;

    always_comb
    begin
        if (cmd.find_a_start)
        begin
            par_raddr = edge_rdata[2*VERT_W-1:VERT_W];
        end
        else if (cmd.find_b_start)
        begin
            par_raddr = eb_reg;
        end
        else
        begin
            par_raddr = pdata;
        end
    end

    rmc_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (pdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            tcount_reg    <= TRIALS_RESET;
            lfsr_reg      <= LFSR_W'(1);
            last_reg      <= 1'b0;
            j_reg         <= '0;
            total_reg     <= '0;
            e_reg         <= '0;
            k_reg         <= '0;
            comps_reg     <= '0;
            dcnt_reg      <= '0;
            cut_reg       <= '0;
            best_reg      <= CUT_CEILING;
            trials_reg    <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT: vcount_reg <= cfg_data[VCNT_W-1:0];
                    REG_TRIAL_COUNT:  tcount_reg <= cfg_data[TRIAL_W-1:0];
                    REG_RANDOM_SEED:  lfsr_reg   <= seed_load;
                    default:          vcount_reg <= vcount_reg;
                endcase
            end
            if (cmd.load_row)
            begin
                last_reg <= rows.last_row;
                j_reg    <= VCNT_W'(rows.row_index) + VCNT_W'(1);
            end
            if (cmd.scan_step)
            begin
                j_reg <= j_reg + VCNT_W'(1);
            end
            if (edge_we)
            begin
                total_reg <= total_reg + ECNT_W'(1);
            end
            if (cmd.clear_start)
            begin
                k_reg     <= '0;
                comps_reg <= n;
            end
            if (cmd.clear_step)
            begin
                k_reg <= k_reg + VERT_W'(1);
            end
            if (cmd.join_roots && comps_reg != '0)
            begin
                comps_reg <= comps_reg - VCNT_W'(1);
            end
            if (cmd.e_clear)
            begin
                e_reg <= '0;
            end
            if (cmd.e_next)
            begin
                e_reg <= e_reg + ECNT_W'(1);
            end
            if (cmd.div_start)
            begin
                lfsr_reg <= lfsr_next;
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
                if (st.div_last)
                begin
                    e_reg <= ECNT_W'(rem_next[EADDR_W-1:0]);
                end
            end
            if (cmd.count_clear)
            begin
                cut_reg <= '0;
            end
            if (cmd.count && st.roots_differ && cut_reg != CUT_CEILING)
            begin
                cut_reg <= cut_reg + CUT_W'(1);
            end
            if (cmd.set_flag)
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.trial_init)
            begin
                flag_reg   <= 1'b0;
                best_reg   <= CUT_CEILING;
                trials_reg <= (tcount_reg == '0) ? TRIAL_W'(1) : tcount_reg;
            end
            if (cmd.trial_end)
            begin
                trials_reg <= trials_reg - TRIAL_W'(1);
                if (cut_reg < best_reg)
                begin
                    best_reg <= cut_reg;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= '0;
            end
            else if (cuts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            row_reg  <= rows.row_index;
            bits_reg <= rows.row_bits;
        end
        if (cmd.find_a_start)
        begin
            cur_reg <= edge_rdata[2*VERT_W-1:VERT_W];
            eb_reg  <= edge_rdata[VERT_W-1:0];
        end
        else if (cmd.find_b_start)
        begin
            root_a_reg <= cur_reg;
            cur_reg    <= eb_reg;
        end
        else if (cmd.walk && !st.root_hit)
        begin
            cur_reg <= pdata;
        end
        if (cmd.div_start)
        begin
            dvd_reg <= lfsr_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[LFSR_W-2:0], 1'b0};
            rem_reg <= rem_next[EADDR_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_cut_reg  <= flag_reg ? '0 : best_reg;
            out_flag_reg <= flag_reg;
        end
    end

    assign rows.ready        = cmd.in_ready;
    assign cuts.valid        = out_valid_reg;
    assign cuts.min_cut      = out_cut_reg;
    assign cuts.disconnected = out_flag_reg;

    always_comb
    begin
        st              = '0;
        st.in_valid     = rows.valid;
        st.scan_done    = j_reg >= n;
        st.last_row     = last_reg;
        st.clear_last   = VCNT_W'(k_reg) == n - VCNT_W'(1);
        st.total_zero   = total_reg == '0;
        st.comps_one    = comps_reg == VCNT_W'(1);
        st.comps_gt2    = comps_reg > VCNT_W'(2);
        st.div_last     = dcnt_reg == DCNT_W'(LFSR_W - 1);
        st.root_hit     = pdata == cur_reg;
        st.roots_differ = cur_reg != root_a_reg;
        st.e_last       = e_reg == total_reg - ECNT_W'(1);
        st.trials_last  = trials_reg == TRIAL_W'(1);
        st.out_free     = !out_valid_reg || cuts.ready;
    end
endmodule

/* hw/rtl/randomized_min_cut_contraction_top.sv */
// karger min cut over a graph of up to 16 vertices. each row word scans the columns above the
// diagonal (vertex_count - row_index - 1 of them); the last row then runs a connectivity pass
// and, when the graph has edges and is connected, trial_count contraction trials before the
// result word. each edge visit does two union-find walks, one parent hop at a time, on the
// parent ram with its one read port; each random pick adds a check and the bit-serial lfsr
// mod edge count. a trial makes at least n - 2 picks.
module randomized_min_cut_contraction_top (
    input  logic                           clk,
    input  logic                           rst_n,
    rmc_row_if.sink                        rows,
    rmc_res_if.source                      cuts,
    input  logic                           cfg_we,
    input  logic [rmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rmc_pkg::*;

    cmd_t  cmd;
    stat_t st;

    rmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    rmc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rows      (rows),
        .cuts      (cuts),
        .cmd       (cmd),
        .st        (st)
    );

    a_flag_zero_cut: assert property (@(posedge clk) disable iff (!rst_n)
        cuts.valid && cuts.disconnected |-> cuts.min_cut == '0)
        else $error("disconnected word with nonzero cut");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending word");

    a_join_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.join_roots |-> st.roots_differ && st.root_hit)
        else $error("join of equal roots");

    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rows.ready |-> !cmd.walk && !cmd.div_step && !cmd.scan_step)
        else $error("row accepted while busy");
endmodule
